### rtl/disc_bit_partial_key_lookup_assert.svh
// Assertion macros used by the partial-key lookup module.
// Each macro names the clock clk and the reset rst of the module that uses it.
`ifndef DISC_BIT_PARTIAL_KEY_LOOKUP_ASSERT_SVH
`define DISC_BIT_PARTIAL_KEY_LOOKUP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBPK_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dbpk assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DBPK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dbpk assertion failed");

`endif

### rtl/dbpk_pkg.sv
package dbpk_pkg;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_MASK_WR  = 2'd0,
    OP_RANK_WR  = 2'd1,
    OP_KEY_BYTE = 2'd2,
    OP_KEY_END  = 2'd3
  } opcode_t;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_RANK_COUNT  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MASK_LENGTH = 1'b1;

  // The key byte counter stops here.
  localparam logic [6:0] KEY_POS_MAX = 7'd127;
  // A total rank above this cannot address the 64-bit partial key.
  localparam logic [9:0] RANK_TOTAL_LIMIT = 10'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_EV,
    ST_MASK_RD,
    ST_MASK_EV,
    ST_WALK_RD,
    ST_WALK_EV,
    ST_DONE
  } state_t;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int b = 0; b < 8; b++) begin
      c = c + {3'b000, v[b]};
    end
    return c;
  endfunction

  // Parallel bit extract of one byte, most significant selected bit first.
  function automatic logic [7:0] extract8(input logic [7:0] v, input logic [7:0] m);
    logic [7:0] r;
    r = '0;
    for (int b = 7; b >= 0; b--) begin
      if (m[b]) begin
        r = {r[6:0], v[b]};
      end
    end
    return r;
  endfunction

endpackage

### rtl/dbpk_if.sv
interface dbpk_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] table_index;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output opcode, output table_index, output data_byte,
                  output last_byte, input ready);
  modport sink (input valid, input opcode, input table_index, input data_byte,
                input last_byte, output ready);
endinterface

interface dbpk_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  position;
  logic [63:0] partial_key;
  logic        rank_error;

  modport source (output valid, output position, output partial_key, output rank_error,
                  input ready);
  modport sink (input valid, input position, input partial_key, input rank_error,
                output ready);
endinterface

### rtl/disc_bit_partial_key_lookup.sv
// Discriminative-bit partial-key lookup.
// Requests arrive on req: opcode 0 writes a mask byte, 1 writes a rank entry,
// 2 streams one key byte (last_byte marks the final one) and 3 ends an empty
// or already streamed key. Each key end produces one result on rsp: the entry
// position, the gathered partial key and the rank error flag.
// Table writes complete in the idle state. A key byte whose position lies inside
// the mask is evaluated in a second state, since the mask byte is read from a
// synchronous memory first; other key bytes complete in the idle state. A key end
// then runs a pass over the L mask bytes in use, each read and then evaluated,
// followed by the rank walk over the N rank entries in use, every entry read once.
// The result is then loaded into the output register from the done state, and the
// block returns to idle, where the next request is taken.
// Only one request is in work at a time; req.ready is high while the block
// waits for the next request.
// Reset clears the configuration registers, the key accumulator and the byte
// counter; the table memories are not cleared and must be written before use.
// The result sits in an output register, so the next request is accepted while
// the receiver stalls; a second result waits until the first has been taken.
module disc_bit_partial_key_lookup #(
  parameter int MASK_BYTES   = 64,
  parameter int RANK_ENTRIES = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dbpk_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dbpk_pkg::CFG_DATA_W-1:0]  cfg_data,
  dbpk_req_if.sink                        req,
  dbpk_rsp_if.source                      rsp
);

  `include "disc_bit_partial_key_lookup_assert.svh"

  // Memory address widths; a depth of one still needs one address bit.
  localparam int MAW = (MASK_BYTES > 1) ? $clog2(MASK_BYTES) : 1;
  localparam int RAW = (RANK_ENTRIES > 1) ? $clog2(RANK_ENTRIES) : 1;
  // Caps that bring the table depths into the ranges of the counters.
  localparam int MASK_CAP = (MASK_BYTES > 127) ? 127 : MASK_BYTES;
  localparam int RANK_CAP = (RANK_ENTRIES > 255) ? 255 : RANK_ENTRIES;

  dbpk_pkg::state_t state, state_next;

  logic [7:0]  rank_count;
  logic [6:0]  mask_length;

  logic [63:0] key_acc, key_acc_next;
  logic [6:0]  key_pos, key_pos_next;
  logic [9:0]  rank_total, rank_total_next;
  logic [6:0]  mask_idx, mask_idx_next;
  logic [7:0]  walk_idx, walk_idx_next;
  logic [7:0]  walk_pos, walk_pos_next;
  logic [7:0]  cur_rank, cur_rank_next;
  logic        head_mode, head_mode_next;
  logic        err, err_next;
  logic        load;

  logic [7:0]  held_data;
  logic        held_last;

  logic        res_valid;
  logic [7:0]  res_position;
  logic [63:0] res_key;
  logic        res_error;

  logic        accept;
  logic [6:0]  len;
  logic [7:0]  walk_n;

  logic           mask_we;
  logic           rank_we;
  logic [MAW+7:0] mask_waddr_wide;
  logic [RAW+7:0] rank_waddr_wide;
  logic [6:0]     mask_rsel;
  logic [MAW+6:0] mask_raddr_wide;
  logic [RAW+7:0] rank_raddr_wide;
  logic [7:0]     mask_rdata;
  logic [7:0]     rank_rdata;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == dbpk_pkg::ST_IDLE);

  // Mask bytes in use and rank entries walked, bounded by the table depths.
  assign len    = (mask_length < 7'(MASK_CAP)) ? mask_length : 7'(MASK_CAP);
  assign walk_n = (rank_count < 8'(RANK_CAP)) ? rank_count : 8'(RANK_CAP);

  // Table writes; indexes beyond a table are dropped.
  assign mask_we = accept && (dbpk_pkg::opcode_t'(req.opcode) == dbpk_pkg::OP_MASK_WR) &&
                   ({24'd0, req.table_index} < 32'(MASK_BYTES));
  assign rank_we = accept && (dbpk_pkg::opcode_t'(req.opcode) == dbpk_pkg::OP_RANK_WR) &&
                   ({24'd0, req.table_index} < 32'(RANK_ENTRIES));
  assign mask_waddr_wide = {{MAW{1'b0}}, req.table_index};
  assign rank_waddr_wide = {{RAW{1'b0}}, req.table_index};

  // The key byte read happens from idle, the finishing pass reads in order.
  assign mask_rsel       = (state == dbpk_pkg::ST_IDLE) ? key_pos : mask_idx;
  assign mask_raddr_wide = {{MAW{1'b0}}, mask_rsel};
  assign rank_raddr_wide = {{RAW{1'b0}}, walk_idx};

  dbpk_ram #(
    .DEPTH (MASK_BYTES),
    .AW    (MAW)
  ) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (mask_waddr_wide[MAW-1:0]),
    .wdata (req.data_byte),
    .raddr (mask_raddr_wide[MAW-1:0]),
    .rdata (mask_rdata)
  );

  dbpk_ram #(
    .DEPTH (RANK_ENTRIES),
    .AW    (RAW)
  ) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr_wide[RAW-1:0]),
    .wdata (req.data_byte),
    .raddr (rank_raddr_wide[RAW-1:0]),
    .rdata (rank_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_count  <= '0;
      mask_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dbpk_pkg::CFG_RANK_COUNT:  rank_count  <= cfg_data;
        dbpk_pkg::CFG_MASK_LENGTH: mask_length <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Sequencer: key byte gathering, the finishing mask pass and the rank walk.
  always_comb begin
    logic [3:0] pop;
    logic [9:0] bit_idx;
    logic       head_eval;
    logic       key_bit;

    state_next      = state;
    key_acc_next    = key_acc;
    key_pos_next    = key_pos;
    rank_total_next = rank_total;
    mask_idx_next   = mask_idx;
    walk_idx_next   = walk_idx;
    walk_pos_next   = walk_pos;
    cur_rank_next   = cur_rank;
    head_mode_next  = head_mode;
    err_next        = err;
    load            = 1'b0;
    pop             = dbpk_pkg::pop8(mask_rdata);
    head_eval       = head_mode || (rank_rdata < cur_rank);
    bit_idx         = rank_total - 10'd1 - {2'b00, rank_rdata};
    key_bit         = 1'b0;

    unique case (state)
      dbpk_pkg::ST_IDLE: begin
        if (req.valid) begin
          unique case (dbpk_pkg::opcode_t'(req.opcode))
            dbpk_pkg::OP_MASK_WR, dbpk_pkg::OP_RANK_WR: ;
            dbpk_pkg::OP_KEY_BYTE: begin
              if (key_pos != dbpk_pkg::KEY_POS_MAX) begin
                key_pos_next = key_pos + 7'd1;
              end
              if (key_pos < len) begin
                state_next = dbpk_pkg::ST_KEY_EV;
              end else if (req.last_byte) begin
                state_next      = dbpk_pkg::ST_MASK_RD;
                mask_idx_next   = '0;
                rank_total_next = '0;
              end
            end
            dbpk_pkg::OP_KEY_END: begin
              state_next      = dbpk_pkg::ST_MASK_RD;
              mask_idx_next   = '0;
              rank_total_next = '0;
            end
          endcase
        end
      end

      dbpk_pkg::ST_KEY_EV: begin
        key_acc_next = (key_acc << pop) | {56'd0, dbpk_pkg::extract8(held_data, mask_rdata)};
        if (held_last) begin
          state_next      = dbpk_pkg::ST_MASK_RD;
          mask_idx_next   = '0;
          rank_total_next = '0;
        end else begin
          state_next = dbpk_pkg::ST_IDLE;
        end
      end

      dbpk_pkg::ST_MASK_RD: begin
        if (mask_idx < len) begin
          state_next = dbpk_pkg::ST_MASK_EV;
        end else begin
          state_next     = dbpk_pkg::ST_WALK_RD;
          err_next       = (rank_total > dbpk_pkg::RANK_TOTAL_LIMIT);
          walk_idx_next  = '0;
          walk_pos_next  = '0;
          head_mode_next = 1'b1;
        end
      end

      dbpk_pkg::ST_MASK_EV: begin
        // Every byte in use counts towards the total; those past the key's
        // end also shift the partial key.
        rank_total_next = rank_total + {6'd0, pop};
        if (mask_idx >= key_pos) begin
          key_acc_next = key_acc << pop;
        end
        mask_idx_next = mask_idx + 7'd1;
        state_next    = dbpk_pkg::ST_MASK_RD;
      end

      dbpk_pkg::ST_WALK_RD: begin
        if (walk_idx < walk_n) begin
          state_next = dbpk_pkg::ST_WALK_EV;
        end else begin
          state_next = dbpk_pkg::ST_DONE;
        end
      end

      dbpk_pkg::ST_WALK_EV: begin
        // While skipping, entries at or above the failed rank are passed
        // over; the first lower one is evaluated as the next head at once.
        walk_idx_next = walk_idx + 8'd1;
        if (head_eval) begin
          if ({2'b00, rank_rdata} >= rank_total) begin
            err_next = 1'b1;
          end else if (bit_idx < 10'd64) begin
            key_bit = key_acc[bit_idx[5:0]];
          end
          if (key_bit) begin
            walk_pos_next  = walk_idx + 8'd1;
            head_mode_next = 1'b1;
          end else begin
            cur_rank_next  = rank_rdata;
            head_mode_next = 1'b0;
          end
        end
        state_next = dbpk_pkg::ST_WALK_RD;
      end

      dbpk_pkg::ST_DONE: begin
        if (!res_valid || rsp.ready) begin
          load         = 1'b1;
          key_acc_next = '0;
          key_pos_next = '0;
          state_next   = dbpk_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = dbpk_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dbpk_pkg::ST_IDLE;
      key_acc    <= '0;
      key_pos    <= '0;
      rank_total <= '0;
      mask_idx   <= '0;
      walk_idx   <= '0;
      walk_pos   <= '0;
      head_mode  <= 1'b1;
      err        <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      key_acc    <= key_acc_next;
      key_pos    <= key_pos_next;
      rank_total <= rank_total_next;
      mask_idx   <= mask_idx_next;
      walk_idx   <= walk_idx_next;
      walk_pos   <= walk_pos_next;
      head_mode  <= head_mode_next;
      err        <= err_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_rank <= cur_rank_next;
    if (accept) begin
      held_data <= req.data_byte;
      held_last <= req.last_byte;
    end
    if (load) begin
      res_position <= walk_pos;
      res_key      <= key_acc;
      res_error    <= err;
    end
  end

  assign rsp.valid       = res_valid;
  assign rsp.position    = res_position;
  assign rsp.partial_key = res_key;
  assign rsp.rank_error  = res_error;

  `DBPK_ASSERT_SAME(a_walk_in_range, state == dbpk_pkg::ST_WALK_EV, walk_idx < walk_n)
  `DBPK_ASSERT_SAME(a_mask_in_range, state == dbpk_pkg::ST_MASK_EV, mask_idx < len)
  `DBPK_ASSERT_SAME(a_pos_not_past_walk, state == dbpk_pkg::ST_DONE, walk_pos <= walk_idx)
  `DBPK_ASSERT_NEXT(a_key_cleared, load, (key_acc == 64'd0) && (key_pos == 7'd0) && res_valid)
  `DBPK_ASSERT_SAME(a_result_from_done, $rose(res_valid), $past(state == dbpk_pkg::ST_DONE))

endmodule

### rtl/dbpk_ram.sv
module dbpk_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### tb/disc_bit_partial_key_lookup_test.sv
// Scoreboard for the partial-key lookup: it mirrors the mask and rank tables, builds the
// partial key as requests are accepted and queues one expected lookup per key end.
class lookup_scoreboard #(int MASK_BYTES = 64, int RANK_ENTRIES = 256);

  typedef struct packed {
    logic [7:0]  position;
    logic [63:0] partial_key;
    logic        rank_error;
  } lookup_t;

  bit [7:0]  mask_bytes [MASK_BYTES];
  bit [7:0]  ranks [RANK_ENTRIES];
  bit [63:0] key_bits;
  bit [6:0]  key_pos;
  bit [7:0]  rank_count;
  bit [6:0]  mask_length;
  lookup_t   expected_lookups [$];
  int        mismatches;
  int        lookups_checked;
  int        flagged_lookups;
  int        requests_seen;

  function new();
    key_bits = '0;
    key_pos = '0;
    rank_count = '0;
    mask_length = '0;
  endfunction

  function void set_register(input logic [dbpk_pkg::CFG_INDEX_W-1:0] index, input int value);
    if (index == dbpk_pkg::CFG_RANK_COUNT) begin
      rank_count = value[7:0];
    end else begin
      mask_length = value[6:0];
    end
  endfunction

  function int mask_bytes_in_use();
    return (mask_length < MASK_BYTES) ? int'(mask_length) : MASK_BYTES;
  endfunction

  // Total number of discriminative bits over the mask bytes in use.
  function int mask_weight();
    int total;
    total = 0;
    for (int i = 0; i < mask_bytes_in_use(); i++) begin
      total += $countones(mask_bytes[i]);
    end
    return total & 'h3FF;
  endfunction

  function bit [7:0] gather_bits(input bit [7:0] value, input bit [7:0] mask);
    bit [7:0] r;
    r = '0;
    for (int b = 7; b >= 0; b--) begin
      if (mask[b]) begin
        r = {r[6:0], value[b]};
      end
    end
    return r;
  endfunction

  // Pads the key with the remaining mask bytes, walks the rank table and queues the answer.
  function void close_key();
    lookup_t want;
    int len;
    int total;
    int i;
    int r;
    int bit_index;
    int pos;
    bit hit;
    len = mask_bytes_in_use();
    for (i = key_pos; i < len; i++) begin
      key_bits = key_bits << $countones(mask_bytes[i]);
    end
    total = mask_weight();
    want.rank_error = (total > 64);
    want.partial_key = key_bits;
    i = 0;
    pos = 0;
    while (i < rank_count) begin
      r = ranks[i];
      hit = 1'b0;
      if (r >= total) begin
        want.rank_error = 1'b1;
      end else begin
        bit_index = total - 1 - r;
        if (bit_index < 64) begin
          hit = key_bits[bit_index];
        end
      end
      if (hit) begin
        i++;
        pos = i;
      end else begin
        while (i < rank_count && ranks[i] >= r) begin
          i++;
        end
      end
    end
    want.position = pos[7:0];
    expected_lookups.push_back(want);
    key_bits = '0;
    key_pos = '0;
  endfunction

  function void note_request(input dbpk_pkg::opcode_t op, input bit [7:0] index,
                             input bit [7:0] value, input bit last);
    bit [7:0] m;
    requests_seen++;
    unique case (op)
      dbpk_pkg::OP_MASK_WR: begin
        if (index < MASK_BYTES) begin
          mask_bytes[index] = value;
        end
      end
      dbpk_pkg::OP_RANK_WR: begin
        if (index < RANK_ENTRIES) begin
          ranks[index] = value;
        end
      end
      dbpk_pkg::OP_KEY_END: begin
        close_key();
      end
      default: begin
        if (key_pos < mask_bytes_in_use()) begin
          m = mask_bytes[key_pos];
          key_bits = (key_bits << $countones(m)) | gather_bits(value, m);
        end
        if (key_pos < dbpk_pkg::KEY_POS_MAX) begin
          key_pos++;
        end
        if (last) begin
          close_key();
        end
      end
    endcase
  endfunction

  function void check_lookup(input logic [7:0] position, input logic [63:0] partial_key,
                             input logic rank_error);
    lookup_t want;
    if (expected_lookups.size() == 0) begin
      $error("unexpected lookup result: position %0d partial_key %h rank_error %b",
             position, partial_key, rank_error);
      mismatches++;
      return;
    end
    want = expected_lookups.pop_front();
    lookups_checked++;
    if (want.rank_error) begin
      flagged_lookups++;
    end
    if (position !== want.position) begin
      $error("position: expected %0d, got %0d", want.position, position);
      mismatches++;
    end
    if (partial_key !== want.partial_key) begin
      $error("partial_key: expected %h, got %h", want.partial_key, partial_key);
      mismatches++;
    end
    if (rank_error !== want.rank_error) begin
      $error("rank_error: expected %b, got %b", want.rank_error, rank_error);
      mismatches++;
    end
  endfunction

  function int pending();
    return expected_lookups.size();
  endfunction

endclass

module disc_bit_partial_key_lookup_test;

  localparam int MASK_BYTES   = 64;
  localparam int RANK_ENTRIES = 256;
  // Twelve time units per cycle; the limit is far beyond the slowest correct run,
  // where every request would be a key end over the full mask and rank tables.
  localparam longint unsigned RUN_LIMIT = 64'd60_000_000;
  // Once the last lookup has arrived, a table write or key byte may still be in work.
  // The wait of QUIET_CYCLES covers it with a margin.
  localparam int QUIET_CYCLES = 20;

  logic clk = 1'b0;
  logic rst;
  logic                             cfg_we;
  logic [dbpk_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [dbpk_pkg::CFG_DATA_W-1:0]  cfg_data;

  dbpk_req_if req_ch ();
  dbpk_rsp_if rsp_ch ();

  lookup_scoreboard #(MASK_BYTES, RANK_ENTRIES) sb;

  // Pacing knobs, changed between phases only.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // A non-zero hold request starts a hold-off in which the receiver refuses results; the value sets its length.
  int hold_request   = 0;
  int hold_left      = 0;
  int longest_hold   = 0;
  int stalled_in_hold = 0;
  int phase_items    = 0;
  int phases_run     = 0;

  disc_bit_partial_key_lookup #(
    .MASK_BYTES  (MASK_BYTES),
    .RANK_ENTRIES(RANK_ENTRIES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  always #6 clk = ~clk;

  // Watchdog: if the block hangs, the run still ends with a verdict.
  initial begin
    #(RUN_LIMIT);
    $display("disc_bit_partial_key_lookup_test NOT OK");
    $finish;
  end

  // Requests are handed to the scoreboard at the edge that accepts them, so the prediction
  // follows the order the block sees, whatever the pacing.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      sb.note_request(dbpk_pkg::opcode_t'(req_ch.opcode), req_ch.table_index,
                      req_ch.data_byte, req_ch.last_byte);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_lookup(rsp_ch.position, rsp_ch.partial_key, rsp_ch.rank_error);
    end
  end

  // Counts the cycles in which a request is held back while the receiver is on hold; the block
  // may then be busy with a lookup or waiting with its result register full.
  always @(posedge clk) begin
    if (!rst && hold_left > 0 && req_ch.valid && !req_ch.ready) begin
      stalled_in_hold++;
    end
  end

  // Result receiver. The long hold-off is timed here, cycle by cycle, while the sender
  // carries on offering requests in its own process.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        if (hold_request > longest_hold) begin
          longest_hold = hold_request;
        end
        hold_request = 0;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offers one request, with random idle cycles in front of it, and returns at the edge that
  // accepts it. Valid stays high on return, so back-to-back requests need no extra edge.
  task automatic send_request(input dbpk_pkg::opcode_t op, input logic [7:0] index,
                              input logic [7:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.table_index <= index;
    req_ch.data_byte   <= value;
    req_ch.last_byte   <= last;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
    // A mask write beyond the table is dropped by the block and does not count as work.
    if (!(op == dbpk_pkg::OP_MASK_WR && index >= MASK_BYTES)) begin
      phase_items++;
    end
  endtask

  // Lowers valid, then waits for every outstanding lookup and for the block to settle.
  task automatic wait_until_quiet();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) begin
      @(posedge clk);
    end
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [dbpk_pkg::CFG_INDEX_W-1:0] index,
                                input int value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value[dbpk_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.set_register(index, value);
  endtask

  // Mask bytes are kept sparse for long masks so that the total rank mostly stays within
  // 64; now and then a dense byte pushes it over and the rank error shows up.
  function automatic logic [7:0] mask_value(input int len);
    logic [7:0] m;
    if (len == 0 || $urandom_range(99) < ((len > 8) ? 3 : 15)) begin
      return 8'($urandom_range(255));
    end
    for (int b = 0; b < 8; b++) begin
      m[b] = ($urandom_range(8 * len - 1) < 40);
    end
    return m;
  endfunction

  // Ranks mostly address a real bit of the partial key; a few lie outside the total.
  function automatic logic [7:0] rank_value();
    int total;
    total = sb.mask_weight();
    if (total == 0 || $urandom_range(99) < 8) begin
      return 8'($urandom_range(255));
    end
    return 8'($urandom_range((total > 256) ? 255 : total - 1));
  endfunction

  function automatic logic [7:0] key_value();
    if ($urandom_range(99) < 15) begin
      return $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return 8'($urandom_range(255));
  endfunction

  // Streams one key of the given length and closes it, either with the last-byte flag or
  // with an explicit key end request. A zero length gives the empty key.
  task automatic send_key(input int len);
    if (len > 0 && $urandom_range(99) < 70) begin
      for (int j = 0; j < len; j++) begin
        send_request(dbpk_pkg::OP_KEY_BYTE, 8'($urandom_range(255)), key_value(),
                     (j == len - 1));
      end
    end else begin
      for (int j = 0; j < len; j++) begin
        send_request(dbpk_pkg::OP_KEY_BYTE, 8'($urandom_range(255)), key_value(), 1'b0);
      end
      send_request(dbpk_pkg::OP_KEY_END, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   1'b0);
    end
  endtask

  // Writes every mask byte and rank entry that a lookup under the current settings can read,
  // so that no lookup ever touches an unwritten entry.
  task automatic load_tables();
    int len;
    len = sb.mask_bytes_in_use();
    for (int i = 0; i < len; i++) begin
      send_request(dbpk_pkg::OP_MASK_WR, 8'(i), mask_value(len), 1'($urandom_range(1)));
    end
    for (int i = 0; i < int'(sb.rank_count); i++) begin
      send_request(dbpk_pkg::OP_RANK_WR, 8'(i), rank_value(), 1'($urandom_range(1)));
    end
  endtask

  // Mostly well-formed keys of lengths up to two bytes past the mask length, mixed with table
  // rewrites and a share of requests whose every field is random.
  task automatic random_traffic(input int count);
    int len;
    int pick;
    int key_len;
    len = sb.mask_bytes_in_use();
    while (phase_items < count) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_request(dbpk_pkg::OP_MASK_WR, 8'($urandom_range(MASK_BYTES - 1)),
                     mask_value(len), 1'($urandom_range(1)));
      end else if (pick < 20) begin
        send_request(dbpk_pkg::OP_RANK_WR,
                     (sb.rank_count > 0 && $urandom_range(3) != 0) ?
                       8'($urandom_range(sb.rank_count - 1)) : 8'($urandom_range(255)),
                     rank_value(), 1'($urandom_range(1)));
      end else if (pick < 28) begin
        send_request(dbpk_pkg::opcode_t'($urandom_range(3)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        if ($urandom_range(99) < 60) begin
          key_len = $urandom_range((len + 2 < 10) ? len + 2 : 10);
        end else begin
          key_len = $urandom_range(len + 2);
        end
        send_key(key_len);
      end
    end
  endtask

  // One phase: new settings while idle, fresh tables, any long keys, then random traffic.
  task automatic run_phase(input int rank_cnt, input int mask_bytes_cfg, input int idle_pct,
                           input int stall_pct, input int count, input int long_keys,
                           input int hold);
    wait_until_quiet();
    write_register(dbpk_pkg::CFG_RANK_COUNT, rank_cnt);
    write_register(dbpk_pkg::CFG_MASK_LENGTH, mask_bytes_cfg);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    phase_items    = 0;
    phases_run++;
    load_tables();
    if (hold > 0) begin
      hold_request = hold;
    end
    // Keys past 127 bytes make the byte counter saturate.
    repeat (long_keys) send_key($urandom_range(128, 140));
    random_traffic(count);
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.opcode      <= dbpk_pkg::OP_KEY_BYTE;
    req_ch.table_index <= '0;
    req_ch.data_byte   <= '0;
    req_ch.last_byte   <= 1'b0;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: three mask bytes carrying ten bits, four rank entries.
    write_register(dbpk_pkg::CFG_RANK_COUNT, 4);
    write_register(dbpk_pkg::CFG_MASK_LENGTH, 3);
    phases_run++;
    // Mask writes beyond the table must leave it untouched.
    send_request(dbpk_pkg::OP_MASK_WR, 8'd255, 8'hFF, 1'b0);
    send_request(dbpk_pkg::OP_MASK_WR, 8'd64, 8'hFF, 1'b1);
    send_request(dbpk_pkg::OP_MASK_WR, 8'd0, 8'hFF, 1'b0);
    send_request(dbpk_pkg::OP_MASK_WR, 8'd1, 8'h81, 1'b0);
    send_request(dbpk_pkg::OP_MASK_WR, 8'd2, 8'h00, 1'b0);
    send_request(dbpk_pkg::OP_RANK_WR, 8'd0, 8'd0, 1'b0);
    send_request(dbpk_pkg::OP_RANK_WR, 8'd1, 8'd9, 1'b0);
    // A rank at or above the total raises the error but the walk carries on.
    send_request(dbpk_pkg::OP_RANK_WR, 8'd2, 8'd255, 1'b0);
    send_request(dbpk_pkg::OP_RANK_WR, 8'd3, 8'd3, 1'b0);
    send_request(dbpk_pkg::OP_RANK_WR, 8'd255, 8'h80, 1'b1);
    // The empty key: a key end with no byte pending.
    send_request(dbpk_pkg::OP_KEY_END, 8'h00, 8'h00, 1'b0);
    // A single byte; the two unused mask bytes still shift the partial key.
    send_request(dbpk_pkg::OP_KEY_BYTE, 8'hFF, 8'hFF, 1'b1);
    send_request(dbpk_pkg::OP_KEY_BYTE, 8'h00, 8'h00, 1'b0);
    send_request(dbpk_pkg::OP_KEY_BYTE, 8'h5A, 8'hA5, 1'b0);
    send_request(dbpk_pkg::OP_KEY_BYTE, 8'hA5, 8'h5A, 1'b1);
    // A key longer than the mask: the bytes past it add no bits.
    send_request(dbpk_pkg::OP_KEY_BYTE, 8'h01, 8'hFF, 1'b0);
    send_request(dbpk_pkg::OP_KEY_BYTE, 8'h02, 8'h00, 1'b0);
    send_request(dbpk_pkg::OP_KEY_BYTE, 8'h04, 8'hFF, 1'b0);
    send_request(dbpk_pkg::OP_KEY_BYTE, 8'h08, 8'hC3, 1'b0);
    send_request(dbpk_pkg::OP_KEY_BYTE, 8'h10, 8'h3C, 1'b0);
    send_request(dbpk_pkg::OP_KEY_END, 8'hFF, 8'hFF, 1'b1);
    // A streamed key closed by a key end request rather than the last-byte flag.
    send_request(dbpk_pkg::OP_KEY_BYTE, 8'h80, 8'h81, 1'b0);
    send_request(dbpk_pkg::OP_KEY_END, 8'h7F, 8'h7E, 1'b0);

    // Random part. The settings run from both extremes through typical small blocks; only
    // the largest setting makes lookups slow, and it gets few keys.
    run_phase(8, 4, 0, 0, 140, 0, 0);
    run_phase(0, 0, 85, 0, 80, 0, 0);
    run_phase(16, 8, 0, 85, 170, 1, 0);
    run_phase(3, 2, 21, 21, 140, 0, 600);
    run_phase(255, 127, 0, 0, 330, 0, 0);
    run_phase(40, 64, 0, 0, 130, 0, 0);
    run_phase(12, 6, 21, 21, 180, 1, 0);

    wait_until_quiet();
    $display("Run covered %0d requests over %0d settings; %0d lookups checked,",
             sb.requests_seen, phases_run, sb.lookups_checked);
    $display("%0d with rank error; receiver held off for %0d cycles, input refused for %0d.",
             sb.flagged_lookups, longest_hold, stalled_in_hold);
    if (sb.mismatches == 0) begin
      $display("disc_bit_partial_key_lookup_test OK");
    end else begin
      $display("disc_bit_partial_key_lookup_test NOT OK");
    end
    $finish;
  end

endmodule
